FILE: design/afu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afu_pkg
// Shared constants, command codes and piecewise-linear sigmoid/tanh tables
// for the activation function unit.
// ----------------------------------------------------------------------------
package afu_pkg;

  // segment count of the sigmoid/tanh tables over [-8, +8]; a power of two
  localparam int TABLE_SEGMENTS = 32;

  localparam int SPAN_Q10      = 16384;
  localparam int HALF_SPAN_Q10 = 8192;
  localparam int ONE_Q10       = 1024;
  localparam int SEG_W         = SPAN_Q10 / TABLE_SEGMENTS;
  localparam int SEG_SH        = $clog2(SEG_W);
  localparam int K_W           = $clog2(TABLE_SEGMENTS);

  // table entries are Q0.16 in [-65536, 65536]
  localparam int TAB_W = 18;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int LEAK_W = 16;
  localparam logic [LEAK_W-1:0] LEAK_RESET = 16'd655;
  localparam logic REG_LEAK_COEF = 1'b0;

  localparam longint ONE_Q30 = longint'(1) << 30;

  typedef enum logic [3:0] {
    CMD_IDENT   = 4'd0,
    CMD_STEP    = 4'd1,
    CMD_SIGMOID = 4'd2,
    CMD_TANH    = 4'd3,
    CMD_RELU    = 4'd4,
    CMD_LEAKY   = 4'd5,
    CMD_D_IDENT = 4'd6,
    CMD_D_STEP  = 4'd7,
    CMD_D_SIG   = 4'd8,
    CMD_D_TANH  = 4'd9,
    CMD_D_RELU  = 4'd10,
    CMD_D_LEAKY = 4'd11
  } cmd_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } afu_adv_t;

  typedef logic signed [TAB_W-1:0] tab_t [TABLE_SEGMENTS+1];

  // unsigned quotient by shift and subtract
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    int              i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-f/1024) in Q2.30, truncated Taylor series
  function automatic longint exp_frac(input longint unsigned f);
    longint unsigned term;
    longint          sum;
    int              i;
    term = longint'(ONE_Q30);
    sum  = ONE_Q30;
    for (i = 1; i <= 16; i++) begin
      term = udiv(term * f, 64'(1024 * i));
      if (i[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  // exp(-t/1024) in Q2.30
  function automatic longint exp_q30(input longint unsigned t);
    longint unsigned e1;
    longint unsigned r;
    longint unsigned n;
    int              i;
    e1 = longint'(exp_frac(longint'(1024)));
    r  = longint'(exp_frac(t & longint'(1023)));
    n  = t >> 10;
    for (i = 0; i < 16; i++) begin
      if (longint'(i) < n) begin
        r = (r * e1) >> 30;
      end
    end
    return longint'(r);
  endfunction

  function automatic longint tab_entry(input int k, input bit tanh_sel);
    longint u;
    longint b;
    longint a;
    longint e;
    longint den;
    longint v;
    u = (longint'(SPAN_Q10) * longint'(k)) / TABLE_SEGMENTS;
    b = u - longint'(HALF_SPAN_Q10);
    a = (b < 0) ? -b : b;
    if (tanh_sel) begin
      e   = exp_q30(longint'(2) * a);
      den = ONE_Q30 + e;
      v   = longint'(udiv((ONE_Q30 - e) * longint'(65536) + den / 2, den));
      return (b < 0) ? -v : v;
    end
    e   = exp_q30(a);
    den = ONE_Q30 + e;
    v   = longint'(udiv((longint'(1) << 46) + den / 2, den));
    return (b < 0) ? longint'(65536) - v : v;
  endfunction

  function automatic tab_t build_tab(input bit tanh_sel);
    tab_t t;
    int   k;
    for (k = 0; k <= TABLE_SEGMENTS; k++) begin
      t[k] = TAB_W'(tab_entry(k, tanh_sel));
    end
    return t;
  endfunction

  localparam tab_t SIG_TAB  = build_tab(1'b0);
  localparam tab_t TANH_TAB = build_tab(1'b1);

  function automatic logic signed [15:0] sat_q10(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      return 16'sh7fff;
    end
    if (v < -20'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/afu_interp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afu_interp
// Three-stage piecewise-linear sigmoid/tanh evaluation: segment lookup,
// slope multiply, truncating add. Result is Q0.16.
// ----------------------------------------------------------------------------
module afu_interp (
  input  wire                                    clk_i,
  input  wire afu_pkg::afu_adv_t                 adv_i,
  input  wire logic signed [15:0]                x_value_i,
  input  wire logic                              use_tanh_i,
  output logic signed [afu_pkg::TAB_W-1:0]       a_value_o
);

  localparam int TAB_W  = afu_pkg::TAB_W;
  localparam int SEG_SH = afu_pkg::SEG_SH;
  localparam int K_W    = afu_pkg::K_W;
  localparam int DIFF_W = TAB_W + 1;
  localparam int PD_W   = DIFF_W + SEG_SH + 1;

  logic signed [16:0]       u;
  logic                     below;
  logic                     above;
  logic [K_W:0]             idx;
  logic [K_W:0]             idx1;
  logic signed [TAB_W-1:0]  tab_k;
  logic signed [TAB_W-1:0]  tab_k1;
  logic signed [TAB_W-1:0]  tab_lo;
  logic signed [TAB_W-1:0]  tab_hi;

  logic signed [TAB_W-1:0]  base1_d, base1_q;
  logic signed [DIFF_W-1:0] diff1_d, diff1_q;
  logic [SEG_SH-1:0]        off1_d, off1_q;

  logic signed [TAB_W-1:0]  base2_q;
  logic signed [PD_W-1:0]   pd2_d, pd2_q;

  logic signed [PD_W-1:0]   pd_neg;
  logic signed [PD_W-1:0]   sh_pos;
  logic signed [PD_W-1:0]   sh_neg;
  logic signed [PD_W-1:0]   q;
  logic signed [PD_W-1:0]   sum;
  logic signed [TAB_W-1:0]  a3_d, a3_q;

  always_comb begin
    u      = 17'(x_value_i) + 17'sd8192;
    below  = (u <= 17'sd0);
    above  = (u >= 17'sd16384);
    idx    = {1'b0, u[SEG_SH+K_W-1:SEG_SH]};
    idx1   = idx + 1'b1;
    off1_d = u[SEG_SH-1:0];
    if (use_tanh_i) begin
      tab_k  = afu_pkg::TANH_TAB[idx];
      tab_k1 = afu_pkg::TANH_TAB[idx1];
      tab_lo = afu_pkg::TANH_TAB[0];
      tab_hi = afu_pkg::TANH_TAB[afu_pkg::TABLE_SEGMENTS];
    end else begin
      tab_k  = afu_pkg::SIG_TAB[idx];
      tab_k1 = afu_pkg::SIG_TAB[idx1];
      tab_lo = afu_pkg::SIG_TAB[0];
      tab_hi = afu_pkg::SIG_TAB[afu_pkg::TABLE_SEGMENTS];
    end
    if (below) begin
      base1_d = tab_lo;
      diff1_d = '0;
    end else if (above) begin
      base1_d = tab_hi;
      diff1_d = '0;
    end else begin
      base1_d = tab_k;
      diff1_d = DIFF_W'(tab_k1) - DIFF_W'(tab_k);
    end
  end

  assign pd2_d = PD_W'(diff1_q) * $signed({1'b0, off1_q});

  // divide by the segment width, truncating toward zero
  always_comb begin
    pd_neg = -pd2_q;
    sh_pos = pd2_q >>> SEG_SH;
    sh_neg = pd_neg >>> SEG_SH;
    q      = pd2_q[PD_W-1] ? -sh_neg : sh_pos;
    sum    = PD_W'(base2_q) + q;
    a3_d   = sum[TAB_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      base1_q <= base1_d;
      diff1_q <= diff1_d;
      off1_q  <= off1_d;
    end
    if (adv_i.s2) begin
      base2_q <= base1_q;
      pd2_q   <= pd2_d;
    end
    if (adv_i.s3) begin
      a3_q <= a3_d;
    end
  end

  assign a_value_o = a3_q;

endmodule
`default_nettype wire

FILE: design/activation_function_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// activation_function_unit
// Q5.10 activation functions and derivatives (identity, step, sigmoid, tanh,
// ReLU, leaky ReLU) with a programmable leaky slope.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    command_i, x_value_i
//   out      output     out_valid_o / out_ready_i  y_value_o
//   cfg      input      psel/penable/pwrite        paddr, pwdata -> prdata
//
// One transaction per cycle sustained while out_ready_i stays high; each
// accepted transaction passes through five register stages: table lookup, slope multiply,
// interpolation add, derivative multiply, output register. Reset clears all
// stage valid bits and loads the leaky slope with 655. A stall holds each
// occupied stage that has no empty stage after it; in_ready_o drops only when all
// five stages hold a transaction.
// ----------------------------------------------------------------------------
module activation_function_unit (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [3:0]                      command_i,
  input  wire logic signed [15:0]              x_value_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [15:0]                   y_value_o,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire logic [afu_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [afu_pkg::DATA_W-1:0]      pwdata,
  output logic [afu_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);

  localparam int TAB_W  = afu_pkg::TAB_W;
  localparam int LEAK_W = afu_pkg::LEAK_W;
  localparam int LP_W   = 16 + LEAK_W + 1;
  localparam int PROD_W = 2 * (TAB_W + 1);

  logic [LEAK_W-1:0] leak_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  afu_pkg::afu_adv_t adv;

  logic [3:0]               cmd1_q, cmd2_q, cmd3_q, cmd4_q;
  logic signed [15:0]       x1_q, x2_q, x3_q, x4_q;
  logic signed [LP_W-1:0]   lp1_d, lp1_q;
  logic signed [LP_W-1:0]   lp_sum;
  logic signed [16:0]       lr2_d, lr2_q, lr3_q, lr4_q;
  logic                     use_tanh;
  logic signed [TAB_W-1:0]  a3;

  logic signed [TAB_W:0]    op_a;
  logic signed [TAB_W:0]    op_b;
  logic signed [PROD_W-1:0] prod4_d, prod4_q;
  logic signed [TAB_W:0]    aq_sum;
  logic signed [15:0]       aq4_d, aq4_q;

  logic signed [PROD_W:0]   dsig;
  logic signed [PROD_W:0]   dtanh;
  logic signed [19:0]       dleak;
  logic signed [19:0]       y_wide;
  logic signed [15:0]       y5_d, y5_q;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == afu_pkg::REG_LEAK_COEF) begin
      prdata = afu_pkg::DATA_W'(leak_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_q <= afu_pkg::LEAK_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == afu_pkg::REG_LEAK_COEF) begin
      leak_q <= pwdata[LEAK_W-1:0];
    end
  end

  // stage enables
  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  assign adv.s1 = en1;
  assign adv.s2 = en2;
  assign adv.s3 = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  assign use_tanh = (command_i == afu_pkg::CMD_TANH) || (command_i == afu_pkg::CMD_D_TANH);

  afu_interp u_interp (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .x_value_i  (x_value_i),
    .use_tanh_i (use_tanh),
    .a_value_o  (a3)
  );

  // leaky product
  assign lp1_d  = LP_W'(x_value_i) * $signed({1'b0, leak_q});
  assign lp_sum = lp1_q + LP_W'(32768);
  assign lr2_d  = 17'(lp_sum >>> 16);

  // derivative multiply and Q0.16 to Q5.10
  always_comb begin
    op_a = (TAB_W+1)'(a3);
    if (cmd3_q == afu_pkg::CMD_D_TANH) begin
      op_b = op_a;
    end else begin
      op_b = (TAB_W+1)'(65536) - op_a;
    end
    prod4_d = PROD_W'(op_a) * PROD_W'(op_b);
    aq_sum  = op_a + (TAB_W+1)'(32);
    aq4_d   = 16'(aq_sum >>> 6);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q <= command_i;
      x1_q   <= x_value_i;
      lp1_q  <= lp1_d;
    end
    if (en2) begin
      cmd2_q <= cmd1_q;
      x2_q   <= x1_q;
      lr2_q  <= lr2_d;
    end
    if (en3) begin
      cmd3_q <= cmd2_q;
      x3_q   <= x2_q;
      lr3_q  <= lr2_q;
    end
    if (en4) begin
      cmd4_q  <= cmd3_q;
      x4_q    <= x3_q;
      lr4_q   <= lr3_q;
      prod4_q <= prod4_d;
      aq4_q   <= aq4_d;
    end
    if (en5) begin
      y5_q <= y5_d;
    end
  end

  // result select
  always_comb begin
    dsig  = (PROD_W+1)'(prod4_q) + (PROD_W+1)'(64'sd2097152);
    dsig  = dsig >>> 22;
    dtanh = (PROD_W+1)'(64'sd4294967296) - (PROD_W+1)'(prod4_q) +
            (PROD_W+1)'(64'sd2097152);
    dtanh = dtanh >>> 22;
    dleak = 20'(({1'b0, leak_q} + (LEAK_W+1)'(32)) >> 6);
    case (cmd4_q)
      afu_pkg::CMD_IDENT:   y_wide = 20'(x4_q);
      afu_pkg::CMD_STEP:    y_wide = (x4_q >= 0) ? 20'(afu_pkg::ONE_Q10) : '0;
      afu_pkg::CMD_SIGMOID,
      afu_pkg::CMD_TANH:    y_wide = 20'(aq4_q);
      afu_pkg::CMD_RELU:    y_wide = (x4_q >= 0) ? 20'(x4_q) : '0;
      afu_pkg::CMD_LEAKY:   y_wide = (x4_q >= 0) ? 20'(x4_q) : 20'(lr4_q);
      afu_pkg::CMD_D_IDENT: y_wide = 20'(afu_pkg::ONE_Q10);
      afu_pkg::CMD_D_STEP:  y_wide = '0;
      afu_pkg::CMD_D_SIG:   y_wide = 20'(dsig);
      afu_pkg::CMD_D_TANH:  y_wide = 20'(dtanh);
      afu_pkg::CMD_D_RELU:  y_wide = (x4_q > 0) ? 20'(afu_pkg::ONE_Q10) : '0;
      afu_pkg::CMD_D_LEAKY: y_wide = (x4_q > 0) ? 20'(afu_pkg::ONE_Q10) : dleak;
      default:              y_wide = '0;
    endcase
    y5_d = afu_pkg::sat_q10(y_wide);
  end

  assign out_valid_o = v5_q;
  assign y_value_o   = y5_q;

`ifndef ASSERT_OFF
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en5) |=> out_valid_o)
    else $error("transaction dropped at output stage");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q))
    else $error("input stalled with an empty stage");

  a_sig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en5 && cmd4_q == afu_pkg::CMD_SIGMOID) |=>
    (y_value_o >= 16'sd0 && y_value_o <= 16'sd1024))
    else $error("sigmoid result out of range");

  a_dtanh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en5 && cmd4_q == afu_pkg::CMD_D_TANH) |=>
    (y_value_o >= 16'sd0 && y_value_o <= 16'sd1024))
    else $error("tanh derivative out of range");
`endif

endmodule
`default_nettype wire
